@@ rtl/dshg_pkg.sv @@
// Shared types and constants for the depth-slice histogram grouping unit.
// No dependencies; imported by every module of the block.
package dshg_pkg;

    // Slice layout
    localparam int NUM_SLICES     = 20;
    localparam int SLICE_W        = 5;
    localparam int EXTREME_SLICES = 9;
    localparam int SHOULDER_BASE  = 9;
    localparam int SHOULDER_MAX   = 14;
    localparam int GROUP_SPAN     = 3;
    localparam int HEAD_GROUPS    = 3;
    localparam int NUM_RECORDS    = 5;

    // Field widths
    localparam int DEPTH_W   = 16;
    localparam int TILE_W    = 10;
    localparam int LOC_W     = 5;
    localparam int SW_W      = 8;
    localparam int COORD_W   = 10;
    localparam int GROUP_W   = 22;
    localparam int REC_W     = 3;
    localparam int SS_W      = 4;
    localparam int SPAN_W    = 2;

    // Remainder width of the slice divider: offsets below 20 * 255
    localparam int REM_W     = 13;
    // Quotient bits resolved in the first divider stage are SLICE_W-1 down to DIV_SPLIT
    localparam int DIV_SPLIT = 2;

    localparam logic [SW_W-1:0]    SLICE_WIDTH_RST = SW_W'(20);
    localparam logic [COORD_W-1:0] COORD_MAX       = '1;
    localparam logic [GROUP_W-1:0] GROUP_MAX       = '1;

    // Extreme point entries
    localparam int NUM_EXT   = 4;
    localparam int EXT_MIN_X = 0;
    localparam int EXT_MAX_X = 1;
    localparam int EXT_MIN_Y = 2;
    localparam int EXT_MAX_Y = 3;

    // Classified pixel handed from the front end to the back end
    typedef struct packed {
        logic                counted;
        logic [SLICE_W-1:0]  slice;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic                last;
    } t_pix;

    // One output record
    typedef struct packed {
        logic [REC_W-1:0]    record_index;
        logic [GROUP_W-1:0]  group_count;
        logic [COORD_W-1:0]  extreme_x;
        logic [COORD_W-1:0]  extreme_y;
        logic                head_start;
        logic [SS_W-1:0]     shoulder_start;
        logic                end_of_run;
    } t_rec;

endpackage

@@ rtl/dshg_front.sv @@
// Front end: accepts pixels, finds the depth slice and the absolute coordinates.
// Four-stage pipeline; uses dshg_pkg. Feeds the classification queue.
module dshg_front
    import dshg_pkg::*;
#(
    parameter int TILE_SIZE     = 20,
    parameter int TILES_PER_ROW = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [SW_W-1:0]     i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [DEPTH_W-1:0]  i_head_depth,
    input  logic [TILE_W-1:0]   i_tile_index,
    input  logic [LOC_W-1:0]    i_local_x,
    input  logic [LOC_W-1:0]    i_local_y,
    input  logic [DEPTH_W-1:0]  i_depth,
    input  logic                i_last,
    output logic                o_push,
    output t_pix                o_pix,
    input  logic                i_full
);

    // Reciprocal of the row length for the tile row / column split
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = (1 << RECIP_SHIFT) / TILES_PER_ROW;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = TILE_W + RECIP_W;
    localparam int QT_W        = TILE_W + $clog2(TILES_PER_ROW + 1);
    localparam int COL_W       = $clog2(TILES_PER_ROW + 1);
    localparam int XW_RAW      = $clog2(TILE_SIZE * TILES_PER_ROW + 32);
    localparam int YW_RAW      = $clog2(TILE_SIZE * 1024 + 32);
    localparam int XW          = (XW_RAW > COORD_W) ? XW_RAW : COORD_W + 1;
    localparam int YW          = (YW_RAW > COORD_W) ? YW_RAW : COORD_W + 1;

    logic [SW_W-1:0]     r_sw;
    logic                r1_valid, r2_valid, r3_valid, r4_valid;
    logic                en;

    // Stage 1
    logic [PROD_W-1:0]   r1_prod;
    logic [TILE_W-1:0]   r1_tile;
    logic [LOC_W-1:0]    r1_lx, r1_ly;
    logic                r1_last, r1_lo, r1_inr;
    logic [REM_W-1:0]    r1_rem;
    logic [SW_W-1:0]     r1_w;
    logic [DEPTH_W:0]    n1_bound;
    logic                n1_lo, n1_inr;
    logic [DEPTH_W-1:0]  n1_dp, n1_lim;

    // Stage 2
    logic [TILE_W-1:0]   r2_q, r2_qt, r2_tile;
    logic [LOC_W-1:0]    r2_lx, r2_ly;
    logic                r2_last, r2_lo, r2_inr;
    logic [REM_W-1:0]    r2_rem;
    logic [SLICE_W-1:0]  r2_k;
    logic [SW_W-1:0]     r2_w;
    logic [TILE_W-1:0]   n2_q;
    logic [QT_W-1:0]     n2_qt;
    logic [REM_W-1:0]    n2_rem;
    logic [SLICE_W-1:0]  n2_k;

    // Stage 3
    logic [TILE_W-1:0]   r3_row;
    logic [COL_W-1:0]    r3_col;
    logic [LOC_W-1:0]    r3_lx, r3_ly;
    logic                r3_last, r3_counted;
    logic [SLICE_W-1:0]  r3_slice;
    logic [TILE_W-1:0]   n3_r, n3_row;
    logic [COL_W-1:0]    n3_col;
    logic [REM_W-1:0]    n3_rem;
    logic [SLICE_W-1:0]  n3_k;

    // Stage 4
    t_pix                r4_pix;
    logic [XW-1:0]       n4_x;
    logic [YW-1:0]       n4_y;

    // Advance the whole pipeline unless the final stage is blocked
    assign en      = !r4_valid || !i_full;
    assign o_ready = en;
    assign o_push  = r4_valid && !i_full;
    assign o_pix   = r4_pix;

    // Range test and offset into the slice grid
    always_comb begin
        n1_bound = {1'b0, i_head_depth} + (DEPTH_W+1)'(r_sw);
        n1_lo    = ({1'b0, i_depth} <= n1_bound);
        n1_dp    = i_depth - i_head_depth - DEPTH_W'(1);
        n1_lim   = DEPTH_W'(r_sw) * DEPTH_W'(NUM_SLICES);
        n1_inr   = !n1_lo && (n1_dp < n1_lim);
    end

    // Upper quotient bits and tile row estimate
    always_comb begin
        n2_rem = r1_rem;
        n2_k   = '0;
        for (int b = SLICE_W - 1; b >= DIV_SPLIT; b--) begin
            if (n2_rem >= (REM_W'(r1_w) << b)) begin
                n2_rem  = n2_rem - (REM_W'(r1_w) << b);
                n2_k[b] = 1'b1;
            end
        end
        n2_q  = r1_prod[RECIP_SHIFT +: TILE_W];
        n2_qt = QT_W'(n2_q) * QT_W'(TILES_PER_ROW);
    end

    // Lower quotient bits and row correction
    always_comb begin
        n3_rem = r2_rem;
        n3_k   = r2_k;
        for (int b = DIV_SPLIT - 1; b >= 0; b--) begin
            if (n3_rem >= (REM_W'(r2_w) << b)) begin
                n3_rem  = n3_rem - (REM_W'(r2_w) << b);
                n3_k[b] = 1'b1;
            end
        end
        n3_r = r2_tile - r2_qt;
        if (n3_r >= TILE_W'(TILES_PER_ROW)) begin
            n3_row = r2_q + TILE_W'(1);
            n3_col = COL_W'(n3_r - TILE_W'(TILES_PER_ROW));
        end else begin
            n3_row = r2_q;
            n3_col = COL_W'(n3_r);
        end
    end

    // Absolute coordinates
    always_comb begin
        n4_x = XW'(r3_col) * XW'(TILE_SIZE) + XW'(r3_lx);
        n4_y = YW'(r3_row) * YW'(TILE_SIZE) + YW'(r3_ly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw     <= SLICE_WIDTH_RST;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sw <= i_cfg_wr_data;
            end
            if (en) begin
                r1_valid <= i_valid;
                r2_valid <= r1_valid;
                r3_valid <= r2_valid;
                r4_valid <= r3_valid;
            end
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod  <= PROD_W'(i_tile_index) * PROD_W'(RECIP);
            r1_tile  <= i_tile_index;
            r1_lx    <= i_local_x;
            r1_ly    <= i_local_y;
            r1_last  <= i_last;
            r1_lo    <= n1_lo;
            r1_inr   <= n1_inr;
            r1_rem   <= n1_dp[REM_W-1:0];
            r1_w     <= r_sw;

            r2_q     <= n2_q;
            r2_qt    <= n2_qt[TILE_W-1:0];
            r2_tile  <= r1_tile;
            r2_lx    <= r1_lx;
            r2_ly    <= r1_ly;
            r2_last  <= r1_last;
            r2_lo    <= r1_lo;
            r2_inr   <= r1_inr;
            r2_rem   <= n2_rem;
            r2_k     <= n2_k;
            r2_w     <= r1_w;

            r3_row     <= n3_row;
            r3_col     <= n3_col;
            r3_lx      <= r2_lx;
            r3_ly      <= r2_ly;
            r3_last    <= r2_last;
            r3_counted <= r2_lo || r2_inr;
            r3_slice   <= r2_lo ? '0 : n3_k;

            r4_pix.counted <= r3_counted;
            r4_pix.slice   <= r3_slice;
            r4_pix.x       <= (n4_x > XW'(COORD_MAX)) ? COORD_MAX : n4_x[COORD_W-1:0];
            r4_pix.y       <= (n4_y > YW'(COORD_MAX)) ? COORD_MAX : n4_y[COORD_W-1:0];
            r4_pix.last    <= r3_last;
        end
    end

endmodule

@@ rtl/dshg_fifo.sv @@
// Short queue of classified pixels between the front and back ends.
// Register array with read and write pointers; uses dshg_pkg for the entry type.
module dshg_fifo
    import dshg_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pix  i_din,
    output logic  o_full,
    input  logic  i_pop,
    output t_pix  o_dout,
    output logic  o_empty
);

    // DEPTH must be a power of two so the pointers wrap on their own
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_pix           r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [AW:0]    r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_dout  = r_mem[r_rd_ptr];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_din;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

@@ rtl/dshg_back.sv @@
// Back end: slice histogram, extreme points and the head/shoulder grouping pass.
// Uses dshg_pkg; drains the classification queue and drives the output register.
module dshg_back
    import dshg_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_pix  i_pix,
    input  logic  i_empty,
    output logic  o_pop,
    output t_rec  o_rec,
    output logic  o_valid,
    input  logic  i_ready
);

    localparam int SUM_W = ((COUNT_WIDTH > GROUP_W) ? COUNT_WIDTH : GROUP_W) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_HEAD,
        ST_SWEEP,
        ST_SUM,
        ST_EMIT
    } t_state;

    t_state                  r_state;
    logic [COUNT_WIDTH-1:0]  r_counts [NUM_SLICES];
    logic [COORD_W-1:0]      r_ext_x  [NUM_EXT];
    logic [COORD_W-1:0]      r_ext_y  [NUM_EXT];
    logic                    r_hs;
    logic [SLICE_W-1:0]      r_ss;
    logic [SLICE_W-1:0]      r_idx;
    logic [COUNT_WIDTH-1:0]  r_best;
    logic [SPAN_W-1:0]       r_j;
    logic [REC_W-1:0]        r_rec;
    logic [GROUP_W-1:0]      r_acc;
    t_rec                    r_out;
    logic                    r_out_valid;

    logic [SLICE_W-1:0]      rd_idx;
    logic [COUNT_WIDTH-1:0]  rd;
    logic                    out_free;
    logic                    ext_upd;
    logic                    n_hs;
    logic [COUNT_WIDTH-1:0]  n_max01;
    logic [SLICE_W-1:0]      n_ss;
    logic [SUM_W-1:0]        n_sum;
    logic [GROUP_W-1:0]      n_acc;

    assign o_pop    = (r_state == ST_ACCUM) && !i_empty;
    assign out_free = !r_out_valid || i_ready;
    assign o_rec    = r_out;
    assign o_valid  = r_out_valid;

    // Shared read port on the counters: pixel slice while accumulating, sweep index otherwise
    always_comb begin
        rd_idx = (r_state == ST_ACCUM) ? i_pix.slice : r_idx;
        rd     = r_counts[rd_idx];
    end

    // Grouping helpers
    always_comb begin
        ext_upd = i_pix.counted && (i_pix.slice < SLICE_W'(EXTREME_SLICES));
        n_max01 = (r_counts[1] > r_counts[0]) ? r_counts[1] : r_counts[0];
        n_hs    = (r_counts[2] > n_max01);
        n_ss    = (rd > r_best) ? r_idx : r_ss;
        if (n_ss > SLICE_W'(SHOULDER_MAX)) begin
            n_ss = SLICE_W'(SHOULDER_MAX);
        end
        n_sum   = SUM_W'(r_acc) + SUM_W'(rd);
        n_acc   = (n_sum > SUM_W'(GROUP_MAX)) ? GROUP_MAX : n_sum[GROUP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SLICES; i++) begin
                r_counts[i] <= '0;
            end
            for (int e = 0; e < NUM_EXT; e++) begin
                r_ext_x[e] <= (e == EXT_MIN_X || e == EXT_MIN_Y) ? COORD_MAX : '0;
                r_ext_y[e] <= (e == EXT_MIN_X || e == EXT_MIN_Y) ? COORD_MAX : '0;
            end
        end else begin
            // Drop the record once it is transferred; a new one is loaded in ST_EMIT
            if (r_state != ST_EMIT && r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_ACCUM: begin
                    if (!i_empty) begin
                        if (i_pix.counted && rd != COUNT_MAX) begin
                            r_counts[i_pix.slice] <= rd + COUNT_WIDTH'(1);
                        end
                        // Keep first-found extremes: replace only on strict improvement
                        if (ext_upd && i_pix.x < r_ext_x[EXT_MIN_X]) begin
                            r_ext_x[EXT_MIN_X] <= i_pix.x;
                            r_ext_y[EXT_MIN_X] <= i_pix.y;
                        end
                        if (ext_upd && i_pix.x > r_ext_x[EXT_MAX_X]) begin
                            r_ext_x[EXT_MAX_X] <= i_pix.x;
                            r_ext_y[EXT_MAX_X] <= i_pix.y;
                        end
                        if (ext_upd && i_pix.y < r_ext_y[EXT_MIN_Y]) begin
                            r_ext_x[EXT_MIN_Y] <= i_pix.x;
                            r_ext_y[EXT_MIN_Y] <= i_pix.y;
                        end
                        if (ext_upd && i_pix.y > r_ext_y[EXT_MAX_Y]) begin
                            r_ext_x[EXT_MAX_Y] <= i_pix.x;
                            r_ext_y[EXT_MAX_Y] <= i_pix.y;
                        end
                        if (i_pix.last) begin
                            r_state <= ST_HEAD;
                        end
                    end
                end

                // Head start: step back one slice when the peak of the first three is last
                ST_HEAD: begin
                    r_hs    <= n_hs;
                    r_idx   <= SLICE_W'(SHOULDER_BASE) + SLICE_W'(n_hs);
                    r_best  <= '0;
                    r_ss    <= SLICE_W'(SHOULDER_BASE);
                    r_state <= ST_SWEEP;
                end

                // Shoulder peak search, one slice per cycle
                ST_SWEEP: begin
                    if (rd > r_best) begin
                        r_best <= rd;
                    end
                    // Track the peak slice, held at the last shoulder start
                    r_ss <= n_ss;
                    if (r_idx == SLICE_W'(NUM_SLICES - 1)) begin
                        r_rec   <= '0;
                        r_idx   <= SLICE_W'(r_hs);
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_state <= ST_SUM;
                    end else begin
                        r_idx <= r_idx + SLICE_W'(1);
                    end
                end

                // Accumulate three consecutive slices
                ST_SUM: begin
                    r_acc <= n_acc;
                    r_idx <= r_idx + SLICE_W'(1);
                    r_j   <= r_j + SPAN_W'(1);
                    if (r_j == SPAN_W'(GROUP_SPAN - 1)) begin
                        r_state <= ST_EMIT;
                    end
                end

                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid              <= 1'b1;
                        r_out.record_index       <= r_rec;
                        r_out.group_count        <= r_acc;
                        r_out.head_start         <= r_hs;
                        r_out.shoulder_start     <= r_ss[SS_W-1:0];
                        if (r_rec == REC_W'(NUM_RECORDS - 1)) begin
                            r_out.extreme_x  <= '0;
                            r_out.extreme_y  <= '0;
                            r_out.end_of_run <= 1'b1;
                            // Return histogram and extremes to their reset values
                            for (int i = 0; i < NUM_SLICES; i++) begin
                                r_counts[i] <= '0;
                            end
                            for (int e = 0; e < NUM_EXT; e++) begin
                                r_ext_x[e] <= (e == EXT_MIN_X || e == EXT_MIN_Y) ?
                                              COORD_MAX : '0;
                                r_ext_y[e] <= (e == EXT_MIN_X || e == EXT_MIN_Y) ?
                                              COORD_MAX : '0;
                            end
                            r_state <= ST_ACCUM;
                        end else begin
                            r_out.extreme_x  <= r_ext_x[r_rec[1:0]];
                            r_out.extreme_y  <= r_ext_y[r_rec[1:0]];
                            r_out.end_of_run <= 1'b0;
                            // Head groups follow each other; shoulder groups start at the peak
                            if (r_rec == REC_W'(HEAD_GROUPS - 1)) begin
                                r_idx <= r_ss;
                            end
                            r_rec   <= r_rec + REC_W'(1);
                            r_j     <= '0;
                            r_acc   <= '0;
                            r_state <= ST_SUM;
                        end
                    end
                end

                default: begin
                    r_state <= ST_ACCUM;
                end
            endcase
        end
    end

endmodule

@@ rtl/depth_slice_histogram_grouping_unit.sv @@
// Depth-slice histogram grouping unit, top level; uses dshg_pkg, front, fifo and back.
// Throughput: one pixel per cycle while the queue has room; it fills during the grouping
// pass. A transferred pixel passes three more front stages and the queue before its
// counter update. After the last pixel the grouping pass loads the records one by one and
// waits while the output stalls. Synchronous active-low reset clears the histogram, the
// extreme points and the queue, and sets slice_width to 20.
module depth_slice_histogram_grouping_unit
    import dshg_pkg::*;
#(
    parameter int TILE_SIZE     = 20,
    parameter int TILES_PER_ROW = 25,
    parameter int COUNT_WIDTH   = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [SW_W-1:0]  i_cfg_wr_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // head_depth[15:0], tile_index[25:16], local_x[30:26], local_y[35:31], depth[51:36]
    input  logic [55:0]      s_axis_tdata,
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // group_count[21:0], extreme_x[31:22], extreme_y[41:32], head_start[42],
    // shoulder_start[46:43]
    output logic [47:0]      m_axis_tdata,
    // record_index[2:0]
    output logic [REC_W-1:0] m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int FIFO_DEPTH = 4;

    logic  push, full, pop, empty;
    t_pix  front_pix, queue_pix;
    t_rec  rec;

    dshg_front #(
        .TILE_SIZE     (TILE_SIZE),
        .TILES_PER_ROW (TILES_PER_ROW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_head_depth  (s_axis_tdata[15:0]),
        .i_tile_index  (s_axis_tdata[25:16]),
        .i_local_x     (s_axis_tdata[30:26]),
        .i_local_y     (s_axis_tdata[35:31]),
        .i_depth       (s_axis_tdata[51:36]),
        .i_last        (s_axis_tlast),
        .o_push        (push),
        .o_pix         (front_pix),
        .i_full        (full)
    );

    dshg_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (front_pix),
        .o_full  (full),
        .i_pop   (pop),
        .o_dout  (queue_pix),
        .o_empty (empty)
    );

    dshg_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (queue_pix),
        .i_empty (empty),
        .o_pop   (pop),
        .o_rec   (rec),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready)
    );

    // Pack the record onto the master side
    assign m_axis_tdata = {1'b0, rec.shoulder_start, rec.head_start, rec.extreme_y,
                           rec.extreme_x, rec.group_count};
    assign m_axis_tuser = rec.record_index;
    assign m_axis_tlast = rec.end_of_run;

endmodule

@@ tb/tb_depth_slice_histogram_grouping_unit.sv @@
// Self-checking testbench for depth_slice_histogram_grouping_unit: streams depth pixels
// in runs that end on tlast and predicts the five grouped records of every run.
// Depends on dshg_pkg and the unit's RTL only.
module tb_depth_slice_histogram_grouping_unit;
    import dshg_pkg::*;

    localparam int TILE_PX       = 20;
    localparam int GRID_COLS     = 25;
    localparam int CNT_W         = 20;
    localparam int DEPTH_TOP     = 65535;
    localparam int SETTLE_CYCLES = 48;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 35;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [DEPTH_W-1:0] head;
        logic [TILE_W-1:0]  tile;
        logic [LOC_W-1:0]   lx;
        logic [LOC_W-1:0]   ly;
        logic [DEPTH_W-1:0] depth;
    } t_pixel;

    // Histogram predictor and store of pending group records
    class hist_scoreboard;
        logic [SW_W-1:0]    slice_width;
        logic [CNT_W-1:0]   slice_cnt [NUM_SLICES];
        logic [COORD_W-1:0] ext_x [NUM_EXT];
        logic [COORD_W-1:0] ext_y [NUM_EXT];
        t_rec               pending_q [$];
        int                 errors;
        int                 reported;

        function new();
            slice_width = SLICE_WIDTH_RST;
            errors      = 0;
            reported    = 0;
            clear_hist();
        endfunction

        function void clear_hist();
            foreach (slice_cnt[i]) slice_cnt[i] = '0;
            ext_x[EXT_MIN_X] = COORD_MAX;
            ext_y[EXT_MIN_X] = COORD_MAX;
            ext_x[EXT_MAX_X] = '0;
            ext_y[EXT_MAX_X] = '0;
            ext_x[EXT_MIN_Y] = COORD_MAX;
            ext_y[EXT_MIN_Y] = COORD_MAX;
            ext_x[EXT_MAX_Y] = '0;
            ext_y[EXT_MAX_Y] = '0;
        endfunction

        // Count one accepted pixel; on the last one queue the five group records
        function void note_pixel(t_pixel p, logic lst);
            int unsigned     h, d, w, k, row, col, x, y, best, hs, ss, first;
            longint unsigned acc;
            int              slice;
            t_rec            r;
            h     = 32'(p.head);
            d     = 32'(p.depth);
            w     = 32'(slice_width);
            slice = -1;
            if (d <= h + w) begin
                slice = 0;
            end else if (w != 0) begin
                k = (d - h - 1) / w;
                if (k < NUM_SLICES) slice = k;
            end

            if (slice >= 0) begin
                if (slice_cnt[slice] != '1) slice_cnt[slice] += 1'b1;
                if (slice < EXTREME_SLICES) begin
                    row = 32'(p.tile) / GRID_COLS;
                    col = 32'(p.tile) % GRID_COLS;
                    x   = TILE_PX * col + 32'(p.lx);
                    y   = TILE_PX * row + 32'(p.ly);
                    if (x > COORD_MAX) x = COORD_MAX;
                    if (y > COORD_MAX) y = COORD_MAX;
                    // strict improvement only: the first point found is kept
                    if (x < ext_x[EXT_MIN_X]) begin
                        ext_x[EXT_MIN_X] = COORD_W'(x);
                        ext_y[EXT_MIN_X] = COORD_W'(y);
                    end
                    if (x > ext_x[EXT_MAX_X]) begin
                        ext_x[EXT_MAX_X] = COORD_W'(x);
                        ext_y[EXT_MAX_X] = COORD_W'(y);
                    end
                    if (y < ext_y[EXT_MIN_Y]) begin
                        ext_x[EXT_MIN_Y] = COORD_W'(x);
                        ext_y[EXT_MIN_Y] = COORD_W'(y);
                    end
                    if (y > ext_y[EXT_MAX_Y]) begin
                        ext_x[EXT_MAX_Y] = COORD_W'(x);
                        ext_y[EXT_MAX_Y] = COORD_W'(y);
                    end
                end
            end

            if (!lst) return;

            // Head group start: peak of slices 0..2, moved back by one when not at 0
            best = 0;
            hs   = 0;
            for (int i = 0; i < GROUP_SPAN; i++) begin
                if (slice_cnt[i] > best) begin
                    best = 32'(slice_cnt[i]);
                    hs   = i;
                end
            end
            if (hs > 0) hs--;

            // Shoulder group start: peak above the head groups, clamped
            best = 0;
            ss   = SHOULDER_BASE;
            for (int i = hs + SHOULDER_BASE; i < NUM_SLICES; i++) begin
                if (slice_cnt[i] > best) begin
                    best = 32'(slice_cnt[i]);
                    ss   = i;
                end
            end
            if (ss > SHOULDER_MAX) ss = SHOULDER_MAX;

            for (int n = 0; n < NUM_RECORDS; n++) begin
                if (n < HEAD_GROUPS) first = hs + GROUP_SPAN * n;
                else first = ss + GROUP_SPAN * (n - HEAD_GROUPS);
                acc = 0;
                for (int i = first; i < first + GROUP_SPAN && i < NUM_SLICES; i++)
                    acc += slice_cnt[i];
                r.record_index   = REC_W'(n);
                r.group_count    = (acc > GROUP_MAX) ? GROUP_MAX : GROUP_W'(acc);
                r.extreme_x      = (n < NUM_EXT) ? ext_x[n] : '0;
                r.extreme_y      = (n < NUM_EXT) ? ext_y[n] : '0;
                r.head_start     = hs[0];
                r.shoulder_start = ss[SS_W-1:0];
                r.end_of_run     = (n == NUM_RECORDS - 1);
                pending_q = {pending_q, r};
            end
            clear_hist();
        endfunction

        // Compare one accepted record with the oldest pending one
        function void check_record(t_rec got);
            t_rec want;
            if (pending_q.size() == 0) begin
                errors++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("unexpected record: idx=%0d count=%0d x=%0d y=%0d",
                             got.record_index, got.group_count, got.extreme_x,
                             got.extreme_y);
                end
                return;
            end
            want = pending_q.pop_front();
            if (got.record_index !== want.record_index ||
                got.group_count !== want.group_count ||
                got.extreme_x !== want.extreme_x ||
                got.extreme_y !== want.extreme_y ||
                got.head_start !== want.head_start ||
                got.shoulder_start !== want.shoulder_start ||
                got.end_of_run !== want.end_of_run) begin
                errors++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $write("record mismatch: exp idx=%0d count=%0d x=%0d y=%0d",
                           want.record_index, want.group_count, want.extreme_x,
                           want.extreme_y);
                    $display(" hs=%0d ss=%0d eor=%0d",
                             want.head_start, want.shoulder_start, want.end_of_run);
                    $write("                 got idx=%0d count=%0d x=%0d y=%0d",
                           got.record_index, got.group_count, got.extreme_x,
                           got.extreme_y);
                    $display(" hs=%0d ss=%0d eor=%0d",
                             got.head_start, got.shoulder_start, got.end_of_run);
                end
            end
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [SW_W-1:0]   i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [55:0]       s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;
    logic [REC_W-1:0]  m_axis_tuser;
    logic              m_axis_tlast;

    hist_scoreboard sb = new();
    bit             steady_src = 1'b0;
    int             ready_hold = 0;
    int             ready_roll;

    depth_slice_histogram_grouping_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Toggle output backpressure: long ready stretches, short and long stalls
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 55) begin
                m_axis_tready <= 1'b1;
                ready_hold    <= $urandom_range(0, 20);
            end else if (ready_roll < 90) begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(8, 30);
            end
        end
    end

    // Check every record transfer
    always @(posedge i_clk) begin : record_monitor
        t_rec seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.record_index   = m_axis_tuser;
            seen.group_count    = m_axis_tdata[21:0];
            seen.extreme_x      = m_axis_tdata[31:22];
            seen.extreme_y      = m_axis_tdata[41:32];
            seen.head_start     = m_axis_tdata[42];
            seen.shoulder_start = m_axis_tdata[46:43];
            seen.end_of_run     = m_axis_tlast;
            sb.check_record(seen);
        end
    end

    function automatic int src_gap();
        int roll;
        if (steady_src) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_pixel mk_pixel(int unsigned head, int unsigned tile,
                                        int unsigned lx, int unsigned ly,
                                        int unsigned depth);
        t_pixel p;
        p.head  = DEPTH_W'(head);
        p.tile  = TILE_W'(tile);
        p.lx    = LOC_W'(lx);
        p.ly    = LOC_W'(ly);
        p.depth = DEPTH_W'(depth);
        return p;
    endfunction

    // Draw a pixel, mostly in the run's favored head and shoulder slices
    function automatic t_pixel rand_pixel(int unsigned head, int hot_head, int hot_sh);
        t_pixel      p;
        int unsigned w, roll, k, lo, hi;
        w      = 32'(sb.slice_width);
        p.head = DEPTH_W'(head);
        p.tile = TILE_W'($urandom_range(0, (1 << TILE_W) - 1));
        p.lx   = LOC_W'($urandom_range(0, TILE_PX - 1));
        p.ly   = LOC_W'($urandom_range(0, TILE_PX - 1));
        roll   = $urandom_range(0, 99);
        if (roll < 8) begin
            p.depth = DEPTH_W'($urandom_range(0, head));
        end else if (roll < 16) begin
            p.depth = DEPTH_W'($urandom);
        end else if (roll < 22) begin
            lo      = head + NUM_SLICES * w + 1;
            p.depth = (lo > DEPTH_TOP) ? DEPTH_W'(DEPTH_TOP) :
                                         DEPTH_W'($urandom_range(lo, DEPTH_TOP));
        end else begin
            if (roll < 50) k = hot_head;
            else if (roll < 72) k = hot_sh;
            else k = $urandom_range(0, NUM_SLICES - 1);
            lo = head + k * w + 1;
            hi = head + (k + 1) * w;
            if (lo > DEPTH_TOP) lo = DEPTH_TOP;
            if (hi > DEPTH_TOP) hi = DEPTH_TOP;
            p.depth = DEPTH_W'($urandom_range(lo, hi));
        end
        // occasional stray head depth
        if ($urandom_range(0, 99) < 5) p.head = DEPTH_W'($urandom);
        return p;
    endfunction

    // Send one pixel after a random gap and hold it until the transfer
    task automatic push_pixel(t_pixel p, logic lst);
        int gap;
        gap = src_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {4'b0, p.depth, p.ly, p.lx, p.tile, p.head};
        s_axis_tlast  <= lst;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(p, lst);
    endtask

    // Hold off the sender until every pending record has arrived
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slice_width(logic [SW_W-1:0] w);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.slice_width = w;
    endtask

    // One person: a run of pixels closed by tlast
    task automatic run_person(int n);
        int unsigned head;
        int          hot_head, hot_sh, roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) head = $urandom_range(0, 2000);
        else if (roll < 80) head = $urandom_range(0, DEPTH_TOP);
        else head = $urandom_range(60000, DEPTH_TOP);
        hot_head   = $urandom_range(0, GROUP_SPAN - 1);
        hot_sh     = $urandom_range(SHOULDER_BASE, NUM_SLICES - 1);
        steady_src = ($urandom_range(0, 99) < 25);
        for (int i = 0; i < n; i++)
            push_pixel(rand_pixel(head, hot_head, hot_sh), i == n - 1);
    endtask

    initial begin : stimulus
        int              phase_items, n, roll;
        logic [SW_W-1:0] w;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty person: a lone last pixel beyond the top slice
        push_pixel(mk_pixel(1000, 0, 0, 0, DEPTH_TOP), 1'b1);
        settle();

        // Slice boundaries at reset width, head 1000; shoulder peak in slice 19
        push_pixel(mk_pixel(1000, 0, 0, 0, 0), 1'b0);
        push_pixel(mk_pixel(1000, 1023, 19, 19, 1020), 1'b0);
        push_pixel(mk_pixel(1000, 24, 19, 0, 1021), 1'b0);
        push_pixel(mk_pixel(1000, 26, 5, 5, 1021), 1'b0);
        push_pixel(mk_pixel(1000, 500, 7, 3, 1041), 1'b0);
        push_pixel(mk_pixel(1000, 1000, 0, 19, 1180), 1'b0);
        push_pixel(mk_pixel(1000, 999, 19, 19, 1181), 1'b0);
        push_pixel(mk_pixel(1000, 0, 0, 0, 1400), 1'b0);
        push_pixel(mk_pixel(1000, 0, 0, 0, 1401), 1'b0);
        push_pixel(mk_pixel(1000, 0, 0, 0, 1390), 1'b1);
        settle();

        // Narrowest slices: peak in slice 2 shifts the head groups by one
        write_slice_width(1);
        push_pixel(mk_pixel(DEPTH_TOP, 1023, 19, 19, DEPTH_TOP), 1'b0);
        push_pixel(mk_pixel(100, 3, 1, 2, 102), 1'b0);
        push_pixel(mk_pixel(100, 50, 2, 2, 103), 1'b0);
        push_pixel(mk_pixel(100, 51, 3, 4, 103), 1'b0);
        push_pixel(mk_pixel(100, 52, 4, 6, 103), 1'b0);
        push_pixel(mk_pixel(100, 7, 0, 0, 112), 1'b1);
        settle();

        // Widest slices, head at zero
        write_slice_width(255);
        push_pixel(mk_pixel(0, 0, 0, 0, DEPTH_TOP), 1'b0);
        push_pixel(mk_pixel(0, 1, 1, 1, 256), 1'b0);
        push_pixel(mk_pixel(0, 2, 2, 2, 256), 1'b0);
        push_pixel(mk_pixel(0, 3, 3, 3, 5100), 1'b0);
        push_pixel(mk_pixel(0, 4, 4, 4, 2550), 1'b1);
        settle();

        // Random persons across several slice widths
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0) w = SW_W'(1);
            else if (ph == 1) w = SW_W'(255);
            else if (ph == NUM_PHASES - 1) w = SLICE_WIDTH_RST;
            else if ($urandom_range(0, 1) == 0) w = SW_W'($urandom_range(1, 8));
            else w = SW_W'($urandom_range(1, 255));
            write_slice_width(w);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) n = $urandom_range(3, 30);
                else if (roll < 90) n = $urandom_range(30, 80);
                else n = $urandom_range(1, 2);
                run_person(n);
                phase_items += n;
                if ($urandom_range(0, 99) < 15) settle();
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("depth_slice_histogram_grouping_unit regression: pass");
        end else begin
            $display("depth_slice_histogram_grouping_unit regression: fail");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #4000000;
        $display("depth_slice_histogram_grouping_unit regression: fail");
        $finish;
    end

endmodule
